// ===== src/fhp_pkg.sv =====
// ----------------------------------------------------------------------------
// Fragment header parser package
// Shared constants, codes, result types and the finish-text lookup.
// ----------------------------------------------------------------------------
package fhp_pkg;

  // Limits and widths.
  localparam int MAX_PAYLOAD = 1000;
  localparam int FRAG_W      = 16;
  localparam int SIZE_W      = 10;
  localparam int IDX_W       = 10;
  localparam int FPOS_W      = 3;
  localparam int FIN_W       = 4;
  localparam int FIN_LEN     = 10;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;

  localparam logic [FRAG_W-1:0] FRAG_MAX  = '1;
  localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(MAX_PAYLOAD);
  localparam logic [FIN_W-1:0]  FIN_END   = FIN_W'(FIN_LEN);

  // Header field positions (count of colons seen).
  localparam logic [FPOS_W-1:0] FPOS_TOTAL   = 3'd0;
  localparam logic [FPOS_W-1:0] FPOS_NUMBER  = 3'd1;
  localparam logic [FPOS_W-1:0] FPOS_NAME    = 3'd3;
  localparam logic [FPOS_W-1:0] FPOS_PAYLOAD = 3'd4;

  // Characters of interest.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_H     = 8'h48;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD      = 3'd0,
    KIND_ACK_NEW      = 3'd1,
    KIND_ACK_REPEAT   = 3'd2,
    KIND_NO_CHANGE    = 3'd3,
    KIND_TIMEOUT_NACK = 3'd4,
    KIND_FINISH       = 3'd5,
    KIND_MALFORMED    = 3'd6
  } kind_t;

  // One result item.
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        payload_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [FRAG_W-1:0] slot_index;
    logic [FRAG_W-1:0] frag_number;
    logic [FRAG_W-1:0] total_frags;
    logic [SIZE_W-1:0] payload_size;
    logic              last;
  } res_t;

  // Push request from the parser to the result queue.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // Expected character of the finish text at a match position.
  function automatic logic [7:0] fin_char(input logic [FIN_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0, 4'd1, 4'd8, 4'd9: c = CH_UNDER;
      4'd2:                   c = CH_F;
      4'd3, 4'd5:             c = CH_I;
      4'd4:                   c = CH_N;
      4'd6:                   c = CH_S;
      4'd7:                   c = CH_H;
      default:                c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/fhp_if.sv =====
// ----------------------------------------------------------------------------
// Fragment header parser channels
// Valid/ready channels for the input bytes and for the result items.
// ----------------------------------------------------------------------------
interface fhp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, operation, data_byte, end_of_datagram, input ready);
  modport sink   (input valid, operation, data_byte, end_of_datagram, output ready);
endinterface

interface fhp_out_if;
  logic                      valid;
  logic                      ready;
  fhp_pkg::kind_t            kind;
  logic [7:0]                payload_byte;
  logic [fhp_pkg::IDX_W-1:0]  byte_index;
  logic [fhp_pkg::FRAG_W-1:0] slot_index;
  logic [fhp_pkg::FRAG_W-1:0] frag_number;
  logic [fhp_pkg::FRAG_W-1:0] total_frags;
  logic [fhp_pkg::SIZE_W-1:0] payload_size;
  logic                      last;

  modport source (output valid, kind, payload_byte, byte_index, slot_index, frag_number,
                  total_frags, payload_size, last, input ready);
  modport sink   (input valid, kind, payload_byte, byte_index, slot_index, frag_number,
                  total_frags, payload_size, last, output ready);
endinterface

// ===== src/fhp_parser.sv =====
// ----------------------------------------------------------------------------
// Fragment header parser core
// Per-byte header parse, payload tagging and end-of-datagram verdict.
// ----------------------------------------------------------------------------
module fhp_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic           operation,
  input  logic [7:0]     data_byte,
  input  logic           end_of_datagram,
  output fhp_pkg::push_t push,
  output fhp_pkg::res_t  res0,
  output fhp_pkg::res_t  res1
);
  import fhp_pkg::*;

  logic [FRAG_W-1:0] expected_r, expected_nxt;
  logic [FPOS_W-1:0] fpos_r, fpos_nxt;
  logic [FRAG_W-1:0] total_r, total_nxt;
  logic [FRAG_W-1:0] number_r, number_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              stopped_r, stopped_nxt;
  logic [IDX_W-1:0]  pcnt_r, pcnt_nxt;
  logic [FIN_W-1:0]  fin_pos_r, fin_pos_nxt;
  logic              fin_ok_r, fin_ok_nxt;

  res_t pay_res, ver_res;
  logic pay_v, ver_v;

  // Decimal accumulate with saturation for fragment values.
  function automatic logic [FRAG_W-1:0] add_frag(input logic [FRAG_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [FRAG_W+3:0] v;
    v = (FRAG_W+4)'({acc, 3'b000}) + (FRAG_W+4)'({acc, 1'b0}) + (FRAG_W+4)'(d);
    return (v > (FRAG_W+4)'(FRAG_MAX)) ? FRAG_MAX : v[FRAG_W-1:0];
  endfunction

  // Decimal accumulate with clamp for the payload size.
  function automatic logic [SIZE_W-1:0] add_size(input logic [SIZE_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [SIZE_W+3:0] v;
    v = (SIZE_W+4)'({acc, 3'b000}) + (SIZE_W+4)'({acc, 1'b0}) + (SIZE_W+4)'(d);
    return (v > (SIZE_W+4)'(SIZE_MAX)) ? SIZE_MAX : v[SIZE_W-1:0];
  endfunction

  // Next state and the results of the current beat.
  always_comb begin
    logic [3:0] digit;
    expected_nxt = expected_r;
    fpos_nxt     = fpos_r;
    total_nxt    = total_r;
    number_nxt   = number_r;
    size_nxt     = size_r;
    stopped_nxt  = stopped_r;
    pcnt_nxt     = pcnt_r;
    fin_pos_nxt  = fin_pos_r;
    fin_ok_nxt   = fin_ok_r;
    pay_v        = 1'b0;
    ver_v        = 1'b0;
    digit        = data_byte[3:0] - CH_ZERO[3:0];

    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = data_byte;
    pay_res.byte_index   = pcnt_r;
    pay_res.slot_index   = expected_r;
    pay_res.frag_number  = number_r;
    pay_res.total_frags  = total_r;
    pay_res.payload_size = size_r;

    ver_res            = '0;
    ver_res.slot_index = expected_r;
    ver_res.last       = 1'b1;

    if (accept) begin
      if (op_t'(operation) == OP_TIMEOUT) begin
        // Timeout drops any partial datagram and nacks the next fragment.
        ver_v               = 1'b1;
        ver_res.kind        = KIND_TIMEOUT_NACK;
        ver_res.frag_number = expected_r + FRAG_W'(1);
        fpos_nxt    = '0;
        total_nxt   = '0;
        number_nxt  = '0;
        size_nxt    = '0;
        stopped_nxt = 1'b0;
        pcnt_nxt    = '0;
        fin_pos_nxt = '0;
        fin_ok_nxt  = 1'b1;
      end else begin
        // Finish text match.
        if (fin_ok_r) begin
          if (fin_pos_r < FIN_END && fin_char(fin_pos_r) == data_byte) begin
            fin_pos_nxt = fin_pos_r + FIN_W'(1);
          end else begin
            fin_ok_nxt = 1'b0;
          end
        end

        if (fpos_r < FPOS_PAYLOAD) begin
          // Header: colon advances the field, leading digits accumulate.
          if (data_byte == CH_COLON) begin
            fpos_nxt    = fpos_r + FPOS_W'(1);
            stopped_nxt = 1'b0;
          end else if (fpos_r < FPOS_NAME && !stopped_r) begin
            if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
              if (fpos_r == FPOS_TOTAL) begin
                total_nxt = add_frag(total_r, digit);
              end else if (fpos_r == FPOS_NUMBER) begin
                number_nxt = add_frag(number_r, digit);
              end else begin
                size_nxt = add_size(size_r, digit);
              end
            end else begin
              stopped_nxt = 1'b1;
            end
          end
        end else begin
          // Payload: only the first size-1 bytes are passed on.
          if ({1'b0, pcnt_r} + (IDX_W+1)'(1) < (IDX_W+1)'(size_r)) begin
            pay_v = 1'b1;
          end
          if (pcnt_r < IDX_W'(MAX_PAYLOAD)) begin
            pcnt_nxt = pcnt_r + IDX_W'(1);
          end
        end

        if (end_of_datagram) begin
          // Verdict from the state after this byte.
          ver_v = 1'b1;
          if (fin_ok_nxt && fin_pos_nxt == FIN_END) begin
            ver_res.kind = KIND_FINISH;
          end else begin
            ver_res.frag_number  = number_nxt;
            ver_res.total_frags  = total_nxt;
            ver_res.payload_size = size_nxt;
            if (fpos_nxt < FPOS_PAYLOAD) begin
              ver_res.kind = KIND_MALFORMED;
            end else if ({1'b0, expected_r} + (FRAG_W+1)'(1) == {1'b0, number_nxt}) begin
              ver_res.kind = KIND_ACK_NEW;
              expected_nxt = expected_r + FRAG_W'(1);
            end else if (expected_r == number_nxt) begin
              ver_res.kind = KIND_ACK_REPEAT;
            end else begin
              ver_res.kind = KIND_NO_CHANGE;
            end
          end
          fpos_nxt    = '0;
          total_nxt   = '0;
          number_nxt  = '0;
          size_nxt    = '0;
          stopped_nxt = 1'b0;
          pcnt_nxt    = '0;
          fin_pos_nxt = '0;
          fin_ok_nxt  = 1'b1;
        end
      end
    end
    pay_res.last = ~ver_v;
  end

  // Order the results into the two push slots.
  always_comb begin
    push.first  = pay_v | ver_v;
    push.second = pay_v & ver_v;
    res0        = pay_v ? pay_res : ver_res;
    res1        = ver_res;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      fpos_r     <= '0;
      total_r    <= '0;
      number_r   <= '0;
      size_r     <= '0;
      stopped_r  <= 1'b0;
      pcnt_r     <= '0;
      fin_pos_r  <= '0;
      fin_ok_r   <= 1'b1;
    end else begin
      expected_r <= expected_nxt;
      fpos_r     <= fpos_nxt;
      total_r    <= total_nxt;
      number_r   <= number_nxt;
      size_r     <= size_nxt;
      stopped_r  <= stopped_nxt;
      pcnt_r     <= pcnt_nxt;
      fin_pos_r  <= fin_pos_nxt;
      fin_ok_r   <= fin_ok_nxt;
    end
  end

endmodule

// ===== src/fhp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Fragment header parser result queue
// Small register queue taking up to two results a cycle, giving one while pop_ready is high.
// ----------------------------------------------------------------------------
module fhp_result_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fhp_pkg::push_t                push,
  input  fhp_pkg::res_t                 res0,
  input  fhp_pkg::res_t                 res1,
  input  logic                          pop_ready,
  output logic                          head_valid,
  output fhp_pkg::res_t                 head,
  output logic [fhp_pkg::FIFO_CW-1:0]   count
);
  import fhp_pkg::*;

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt;
  logic [FIFO_AW-1:0] rd_r, rd_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_r];
  assign count      = cnt_r;
  assign pop        = head_valid & pop_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_nxt  = wr_r + FIFO_AW'(push.first) + FIFO_AW'(push.second);
    rd_nxt  = rd_r + FIFO_AW'(pop);
    cnt_nxt = cnt_r + FIFO_CW'(push.first) + FIFO_CW'(push.second) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_r] <= res0;
    end
    if (push.second) begin
      mem[wr_r + FIFO_AW'(1)] <= res1;
    end
  end

endmodule

// ===== src/fragment_header_parse_and_ack_unit.sv =====
// ----------------------------------------------------------------------------
// Fragment header parse and ack unit
// Parses datagram headers byte by byte, tags payload bytes and acks.
// ----------------------------------------------------------------------------
// A result is queued as its beat is taken and offered once at the queue head.
// Throughput: one input beat per cycle while the queue has room; a beat yields
// one or two results, and a four-entry queue drains one per cycle while ready.
// Input is taken while the queue has room for two results.
// Reset (synchronous, rst_n low): expected index and header state clear,
// the queue empties; no clearing pass is needed.
module fragment_header_parse_and_ack_unit (
  input logic   clk,
  input logic   rst_n,
  fhp_in_if.sink    in_beat,
  fhp_out_if.source out_beat
);
  import fhp_pkg::*;

  push_t              push;
  res_t               res0, res1, head;
  logic               head_valid;
  logic [FIFO_CW-1:0] count;
  logic               accept;

  // Take a beat only when both of its possible results fit.
  assign in_beat.ready = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign accept        = in_beat.valid & in_beat.ready;

  fhp_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .operation       (in_beat.operation),
    .data_byte       (in_beat.data_byte),
    .end_of_datagram (in_beat.end_of_datagram),
    .push            (push),
    .res0            (res0),
    .res1            (res1)
  );

  fhp_result_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res0       (res0),
    .res1       (res1),
    .pop_ready  (out_beat.ready),
    .head_valid (head_valid),
    .head       (head),
    .count      (count)
  );

  // Result channel.
  assign out_beat.valid        = head_valid;
  assign out_beat.kind         = head.kind;
  assign out_beat.payload_byte = head.payload_byte;
  assign out_beat.byte_index   = head.byte_index;
  assign out_beat.slot_index   = head.slot_index;
  assign out_beat.frag_number  = head.frag_number;
  assign out_beat.total_frags  = head.total_frags;
  assign out_beat.payload_size = head.payload_size;
  assign out_beat.last         = head.last;

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A second result is only pushed along with a first.
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("second push without first");

  // Results are only produced for accepted beats.
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.first |-> accept)
    else $error("result pushed without an accepted beat");

  // A timeout beat gives exactly one result.
  a_timeout_single: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op_t'(in_beat.operation) == OP_TIMEOUT) |-> (push.first && !push.second))
    else $error("timeout beat gave wrong result count");

endmodule
